// ----- design/plsc_pkg.sv -----
package plsc_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // fixed field widths of the transaction ports
   localparam int ACTION_W   = 3;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 6;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 6;

   // compare width for position against occupancy + 1
   localparam int CMP_W = ((POSITION_W > CNT_W) ? POSITION_W : CNT_W) + 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INS_FRONT = 3'd0,
      ACT_INS_END   = 3'd1,
      ACT_INS_POS   = 3'd2,
      ACT_DEL_FRONT = 3'd3,
      ACT_DEL_END   = 3'd4,
      ACT_DEL_POS   = 3'd5,
      ACT_DUMP      = 3'd6,
      ACT_COUNT     = 3'd7
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      IDX_ZERO,
      IDX_END,
      IDX_POS
   } idx_sel_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_ONE,
      PTR_LAST,
      PTR_POS,
      PTR_INC,
      PTR_DEC
   } ptr_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_UP,
      WR_DN,
      WR_PUT
   } wr_sel_type;

   typedef enum logic [1:0] {
      OCC_HOLD,
      OCC_INC,
      OCC_DEC
   } occ_op_type;

   typedef enum logic {
      OUT_RESULT,
      OUT_ELEM
   } out_sel_type;

   typedef struct packed {
      logic        load_idx;
      idx_sel_type idx_sel;
      logic        load_val;
      ptr_sel_type ptr_sel;
      wr_sel_type  wr_sel;
      occ_op_type  occ_op;
      logic        out_load;
      out_sel_type out_sel;
      status_type  status;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic one;
      logic full;
      logic ins_pos_ok;
      logic del_pos_ok;
      logic ins_at_tail;
      logic del_at_tail;
      logic ptr_at_idx;
      logic ptr_at_last;
      logic out_free;
   } stat_type;

endpackage

// ----- design/positional_list_store_core.sv -----
// ordered list of up to 32 signed 32-bit values, front at entry 0, one
// operation per request transaction: insert front, end or at a 1-based
// position, delete front, end or at a position, dump, count. every
// operation answers with one response transaction except a dump of a
// non-empty list, which sends one response per element, front first, with
// rsp_last on the final one. a request is taken only when the block is
// idle; count, bad position, empty, full and delete-end go straight to
// the response and insert-end writes first; all may wait on response
// stalls. a positional insert shifts the entries from the index up and a
// positional delete shifts them down, since the element memory moves one
// entry per cycle. a dump first points at the front, then delivers one
// element per cycle while the response side does not stall. no clearing
// pass after reset: only entries below the count are ever read
module positional_list_store_core import plsc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic        [ACTION_W-1:0]   req_action,
   input  logic signed [VALUE_W-1:0]    req_value,
   input  logic        [POSITION_W-1:0] req_position,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic        [STATUS_W-1:0]   rsp_status,
   output logic signed [VALUE_W-1:0]    rsp_element,
   output logic        [COUNT_W-1:0]    rsp_count,
   output logic                         rsp_last
);

   // commands from the sequencer, status back from the datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: decodes the action and steps the shift, put and dump loops
   plsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .stat       (stat),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   // datapath: element memory, occupancy, pointers and the response register
   plsc_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_stall    (rsp_stall),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_count    (rsp_count),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- design/plsc_ctrl.sv -----
module plsc_ctrl import plsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   input  stat_type            stat,
   output logic                req_stall,
   output cmd_type             cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_PUT,
      S_DUMP,
      S_RESP
   } state_type;

   state_type  state_ff, state_in;
   status_type st_ff, st_in;
   action_type action;

   assign action    = action_type'(req_action);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      st_in        = st_ff;
      cmd.load_idx = 1'b0;
      cmd.idx_sel  = IDX_ZERO;
      cmd.load_val = 1'b0;
      cmd.ptr_sel  = PTR_HOLD;
      cmd.wr_sel   = WR_NONE;
      cmd.occ_op   = OCC_HOLD;
      cmd.out_load = 1'b0;
      cmd.out_sel  = OUT_RESULT;
      cmd.status   = st_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               st_in        = ST_OK;
               state_in     = S_RESP;
               cmd.load_val = 1'b1;
               unique case (action)
                  ACT_INS_FRONT: begin
                     if (stat.full) begin
                        st_in = ST_FULL;
                     end else begin
                        cmd.load_idx = 1'b1;
                        cmd.idx_sel  = IDX_ZERO;
                        if (stat.empty) begin
                           state_in = S_PUT;
                        end else begin
                           cmd.ptr_sel = PTR_LAST;
                           state_in    = S_SHIFT_UP;
                        end
                     end
                  end
                  ACT_INS_END: begin
                     if (stat.full) begin
                        st_in = ST_FULL;
                     end else begin
                        cmd.load_idx = 1'b1;
                        cmd.idx_sel  = IDX_END;
                        state_in     = S_PUT;
                     end
                  end
                  ACT_INS_POS: begin
                     if (!stat.ins_pos_ok) begin
                        st_in = ST_BADPOS;
                     end else if (stat.full) begin
                        st_in = ST_FULL;
                     end else begin
                        cmd.load_idx = 1'b1;
                        cmd.idx_sel  = IDX_POS;
                        if (stat.ins_at_tail) begin
                           state_in = S_PUT;
                        end else begin
                           cmd.ptr_sel = PTR_LAST;
                           state_in    = S_SHIFT_UP;
                        end
                     end
                  end
                  ACT_DEL_FRONT: begin
                     if (stat.empty) begin
                        st_in = ST_EMPTY;
                     end else if (stat.one) begin
                        cmd.occ_op = OCC_DEC;
                     end else begin
                        cmd.ptr_sel = PTR_ONE;
                        state_in    = S_SHIFT_DN;
                     end
                  end
                  ACT_DEL_END: begin
                     if (stat.empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        cmd.occ_op = OCC_DEC;
                     end
                  end
                  ACT_DEL_POS: begin
                     if (!stat.del_pos_ok) begin
                        st_in = ST_BADPOS;
                     end else if (stat.del_at_tail) begin
                        cmd.occ_op = OCC_DEC;
                     end else begin
                        cmd.ptr_sel = PTR_POS;
                        state_in    = S_SHIFT_DN;
                     end
                  end
                  ACT_DUMP: begin
                     if (stat.empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        cmd.ptr_sel = PTR_ZERO;
                        state_in    = S_DUMP;
                     end
                  end
                  ACT_COUNT: begin
                     st_in = ST_OK;
                  end
                  default: begin
                     st_in = ST_OK;
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            cmd.wr_sel = WR_UP;
            if (stat.ptr_at_idx) begin
               state_in = S_PUT;
            end else begin
               cmd.ptr_sel = PTR_DEC;
            end
         end
         S_SHIFT_DN: begin
            cmd.wr_sel = WR_DN;
            if (stat.ptr_at_last) begin
               cmd.occ_op = OCC_DEC;
               state_in   = S_RESP;
            end else begin
               cmd.ptr_sel = PTR_INC;
            end
         end
         S_PUT: begin
            cmd.wr_sel = WR_PUT;
            cmd.occ_op = OCC_INC;
            state_in   = S_RESP;
         end
         S_DUMP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_ELEM;
               if (stat.ptr_at_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.ptr_sel = PTR_INC;
               end
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_RESULT;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      st_ff <= st_in;
   end

endmodule

// ----- design/plsc_datapath.sv -----
module plsc_datapath import plsc_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic signed [VALUE_W-1:0]    req_value,
   input  logic        [POSITION_W-1:0] req_position,
   input  logic                         rsp_stall,
   output stat_type                     stat,
   output logic                         rsp_valid,
   output logic        [STATUS_W-1:0]   rsp_status,
   output logic signed [VALUE_W-1:0]    rsp_element,
   output logic        [COUNT_W-1:0]    rsp_count,
   output logic                         rsp_last
);

   logic [VALUE_W-1:0] mem [CAPACITY];

   logic [CNT_W-1:0]   occ_ff, occ_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   last_idx;
   logic [VALUE_W-1:0] val_ff;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   occ_ext;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [VALUE_W-1:0]   rsp_element_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_last_ff;

   assign last_idx = IDX_W'(occ_ff - 1'b1);
   assign pos_ext  = CMP_W'(req_position);
   assign occ_ext  = CMP_W'(occ_ff);

   assign stat.empty       = (occ_ff == '0);
   assign stat.one         = (occ_ff == CNT_W'(1));
   assign stat.full        = (occ_ext >= CMP_W'(CAPACITY));
   assign stat.ins_pos_ok  = (pos_ext != '0) && (pos_ext <= occ_ext + 1'b1);
   assign stat.del_pos_ok  = (pos_ext != '0) && (pos_ext <= occ_ext);
   assign stat.ins_at_tail = (pos_ext == occ_ext + 1'b1);
   assign stat.del_at_tail = (pos_ext == occ_ext);
   assign stat.ptr_at_idx  = (ptr_ff == idx_ff);
   assign stat.ptr_at_last = (ptr_ff == last_idx);
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load_idx) begin
         unique case (cmd.idx_sel)
            IDX_ZERO: idx_in = '0;
            IDX_END:  idx_in = IDX_W'(occ_ff);
            IDX_POS:  idx_in = IDX_W'(req_position - 1'b1);
            default:  idx_in = '0;
         endcase
      end
   end

   always_comb begin
      unique case (cmd.ptr_sel)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_ZERO: ptr_in = '0;
         PTR_ONE:  ptr_in = IDX_W'(1);
         PTR_LAST: ptr_in = last_idx;
         PTR_POS:  ptr_in = IDX_W'(req_position);
         PTR_INC:  ptr_in = ptr_ff + 1'b1;
         PTR_DEC:  ptr_in = ptr_ff - 1'b1;
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = rd_data_ff;
      unique case (cmd.wr_sel)
         WR_NONE: wr_en = 1'b0;
         WR_UP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + 1'b1;
         end
         WR_DN: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff - 1'b1;
         end
         WR_PUT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = val_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      unique case (cmd.occ_op)
         OCC_HOLD: occ_in = occ_ff;
         OCC_INC:  occ_in = occ_ff + 1'b1;
         OCC_DEC:  occ_in = occ_ff - 1'b1;
         default:  occ_in = occ_ff;
      endcase
   end

   // element store, read address is the next pointer so data tracks ptr_ff
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
      ptr_ff <= ptr_in;
      idx_ff <= idx_in;
      if (cmd.load_val) begin
         val_ff <= req_value;
      end
   end

   // result register
   assign rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         rsp_count_ff <= COUNT_W'(occ_ff);
         if (cmd.out_sel == OUT_ELEM) begin
            rsp_status_ff  <= ST_OK;
            rsp_element_ff <= rd_data_ff;
            rsp_last_ff    <= stat.ptr_at_last;
         end else begin
            rsp_status_ff  <= cmd.status;
            rsp_element_ff <= '0;
            rsp_last_ff    <= 1'b1;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
